>>> design/tqcp_pkg.sv
// ----------------------------------------------------------------------------
// tqcp_pkg
// Shared types, register indexes and helpers of the 2Q cache policy unit.
// ----------------------------------------------------------------------------
package tqcp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int LIM_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_LIMIT = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic [31:0]        hit_count;
        logic [31:0]        miss_count;
        logic [31:0]        eviction_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic update;
    } cmd_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

endpackage

>>> design/tqcp_ctrl.sv
// ----------------------------------------------------------------------------
// tqcp_ctrl
// Sequencer: accept a request, run the match pass, then the update pass.
// ----------------------------------------------------------------------------
module tqcp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output tqcp_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The update waits until the output register can take the result.
                if (slot_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/tqcp_datapath.sv
// ----------------------------------------------------------------------------
// tqcp_datapath
// Stores, match logic, replacement updates, counters and result register.
// ----------------------------------------------------------------------------
module tqcp_datapath
#(
    parameter int MAIN_DEPTH  = 16,
    parameter int NEW_DEPTH   = 8,
    parameter int GHOST_DEPTH = 16,
    parameter int KEY_BITS    = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tqcp_pkg::cmd_t                      cmd,
    input  tqcp_pkg::req_t                      in_item,
    input  logic                                cfg_we,
    input  logic [tqcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqcp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tqcp_pkg::rsp_t                      out_item
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int MI = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MC = $clog2(MAIN_DEPTH + 1);
    localparam int NI = (NEW_DEPTH > 1) ? $clog2(NEW_DEPTH) : 1;
    localparam int NC = $clog2(NEW_DEPTH + 1);
    localparam int GI = (GHOST_DEPTH > 1) ? $clog2(GHOST_DEPTH) : 1;
    localparam int GC = $clog2(GHOST_DEPTH + 1);
    localparam int LW = tqcp_pkg::LIM_W;

    // Configuration
    logic [4:0] main_limit_reg;
    logic [3:0] new_limit_reg;
    logic [4:0] ghost_limit_reg;

    // Stores
    logic [KW-1:0]          main_key_reg   [MAIN_DEPTH];
    logic [31:0]            main_val_reg   [MAIN_DEPTH];
    logic [MI-1:0]          main_rec_reg   [MAIN_DEPTH];
    logic [MAIN_DEPTH-1:0]  main_valid_reg;
    logic [KW-1:0]          new_key_reg    [NEW_DEPTH];
    logic [31:0]            new_val_reg    [NEW_DEPTH];
    logic [NI-1:0]          new_head_reg;
    logic [NC-1:0]          new_fill_reg;
    logic [KW-1:0]          ghost_key_reg  [GHOST_DEPTH];
    logic [GC-1:0]          ghost_fill_reg;
    logic [31:0]            hits_reg, misses_reg, evicts_reg;

    logic [KW-1:0]          main_key_next  [MAIN_DEPTH];
    logic [31:0]            main_val_next  [MAIN_DEPTH];
    logic [MI-1:0]          main_rec_next  [MAIN_DEPTH];
    logic [MAIN_DEPTH-1:0]  main_valid_next;
    logic [KW-1:0]          new_key_next   [NEW_DEPTH];
    logic [31:0]            new_val_next   [NEW_DEPTH];
    logic [NI-1:0]          new_head_next;
    logic [NC-1:0]          new_fill_next;
    logic [KW-1:0]          ghost_key_next [GHOST_DEPTH];
    logic [GC-1:0]          ghost_fill_next;
    logic [31:0]            hits_next, misses_next, evicts_next;
    tqcp_pkg::rsp_t         out_item_next;

    // Captured request
    logic          req_mode_reg;
    logic [KW-1:0] req_key_reg;
    logic [31:0]   req_val_reg;

    // Match results
    logic          main_hit_reg, main_hit_c;
    logic [MI-1:0] main_idx_reg, main_idx_c;
    logic          new_hit_reg, new_hit_c;
    logic [NI-1:0] new_idx_reg, new_idx_c;
    logic          ghost_hit_reg, ghost_hit_c;
    logic [GI-1:0] ghost_pos_reg, ghost_pos_c;
    logic [MC-1:0] main_cnt_reg, main_cnt_c;

    tqcp_pkg::rsp_t out_item_reg;

    logic [LW-1:0] main_lim, new_lim, ghost_lim;

    assign out_item = out_item_reg;

    // Effective limits: zero acts as one for the resident stores, and
    // anything above the depth acts as the depth.
    always_comb
    begin
        if (main_limit_reg == 5'd0)
            main_lim = LW'(1);
        else if (LW'(main_limit_reg) > LW'(MAIN_DEPTH))
            main_lim = LW'(MAIN_DEPTH);
        else
            main_lim = LW'(main_limit_reg);

        if (new_limit_reg == 4'd0)
            new_lim = LW'(1);
        else if (LW'(new_limit_reg) > LW'(NEW_DEPTH))
            new_lim = LW'(NEW_DEPTH);
        else
            new_lim = LW'(new_limit_reg);

        if (LW'(ghost_limit_reg) > LW'(GHOST_DEPTH))
            ghost_lim = LW'(GHOST_DEPTH);
        else
            ghost_lim = LW'(ghost_limit_reg);
    end

    // Associative match over all three stores.
    always_comb
    begin
        logic [LW-1:0] off;
        main_hit_c  = 1'b0;
        main_idx_c  = '0;
        main_cnt_c  = '0;
        new_hit_c   = 1'b0;
        new_idx_c   = '0;
        ghost_hit_c = 1'b0;
        ghost_pos_c = '0;
        for (int i = MAIN_DEPTH - 1; i >= 0; i--)
        begin
            if (main_valid_reg[i] && main_key_reg[i] == req_key_reg)
            begin
                main_hit_c = 1'b1;
                main_idx_c = MI'(i);
            end
        end
        for (int i = 0; i < MAIN_DEPTH; i++)
            main_cnt_c = main_cnt_c + MC'(main_valid_reg[i]);
        for (int s = NEW_DEPTH - 1; s >= 0; s--)
        begin
            off = LW'(s) + LW'(NEW_DEPTH) - LW'(new_head_reg);
            if (off >= LW'(NEW_DEPTH))
                off = off - LW'(NEW_DEPTH);
            if (off < LW'(new_fill_reg) && new_key_reg[s] == req_key_reg)
            begin
                new_hit_c = 1'b1;
                new_idx_c = NI'(s);
            end
        end
        for (int j = GHOST_DEPTH - 1; j >= 0; j--)
        begin
            if (LW'(j) < LW'(ghost_fill_reg) && ghost_key_reg[j] == req_key_reg)
            begin
                ghost_hit_c = 1'b1;
                ghost_pos_c = GI'(j);
            end
        end
    end

    // Replacement and counter updates.
    always_comb
    begin
        logic                  ev_inc;
        logic                  victim_evict;
        logic [MAIN_DEPTH-1:0] valid_after;
        logic                  slot_found;
        logic [MI-1:0]         slot;
        logic [MC-1:0]         cnt_m1;
        logic [MI-1:0]         r;
        logic [KW-1:0]         old_key;
        logic [LW-1:0]         sum;
        logic [NI-1:0]         wslot;

        main_key_next   = main_key_reg;
        main_val_next   = main_val_reg;
        main_rec_next   = main_rec_reg;
        main_valid_next = main_valid_reg;
        new_key_next    = new_key_reg;
        new_val_next    = new_val_reg;
        new_head_next   = new_head_reg;
        new_fill_next   = new_fill_reg;
        ghost_key_next  = ghost_key_reg;
        ghost_fill_next = ghost_fill_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        ev_inc          = 1'b0;
        victim_evict    = 1'b0;
        valid_after     = main_valid_reg;
        slot_found      = 1'b0;
        slot            = '0;
        cnt_m1          = main_cnt_reg - MC'(1);
        r               = main_rec_reg[main_idx_reg];
        old_key         = new_key_reg[new_head_reg];
        sum             = '0;
        wslot           = '0;
        out_item_next   = '0;

        out_item_next.hit = main_hit_reg || new_hit_reg;

        if (main_hit_reg)
        begin
            // Move the entry to most recent; younger ones age by one.
            for (int i = 0; i < MAIN_DEPTH; i++)
            begin
                if (main_valid_reg[i] && main_rec_reg[i] < r)
                    main_rec_next[i] = main_rec_reg[i] + MI'(1);
            end
            main_rec_next[main_idx_reg] = '0;
        end

        if (!req_mode_reg)
        begin
            if (main_hit_reg)
                out_item_next.read_value = main_val_reg[main_idx_reg];
            else if (new_hit_reg)
                out_item_next.read_value = new_val_reg[new_idx_reg];
            if (main_hit_reg || new_hit_reg)
                hits_next = tqcp_pkg::sat_inc(hits_reg);
            else
                misses_next = tqcp_pkg::sat_inc(misses_reg);
        end
        else if (main_hit_reg)
        begin
            main_val_next[main_idx_reg] = req_val_reg;
        end
        else if (new_hit_reg)
        begin
            new_val_next[new_idx_reg] = req_val_reg;
        end
        else if (ghost_hit_reg)
        begin
            for (int j = 0; j < GHOST_DEPTH - 1; j++)
            begin
                if (GI'(j) >= ghost_pos_reg)
                    ghost_key_next[j] = ghost_key_reg[j+1];
            end
            ghost_fill_next = ghost_fill_reg - GC'(1);

            // Recencies of valid entries form 0..count-1, so the LRU entry
            // is the one whose recency equals count-1.
            victim_evict = (LW'(main_cnt_reg) >= main_lim);
            if (victim_evict)
            begin
                ev_inc = 1'b1;
                for (int i = 0; i < MAIN_DEPTH; i++)
                begin
                    if (main_valid_reg[i] && MC'(main_rec_reg[i]) == cnt_m1)
                        valid_after[i] = 1'b0;
                end
            end
            for (int i = MAIN_DEPTH - 1; i >= 0; i--)
            begin
                if (!valid_after[i])
                begin
                    slot_found = 1'b1;
                    slot       = MI'(i);
                end
            end
            for (int i = 0; i < MAIN_DEPTH; i++)
            begin
                if (valid_after[i])
                    main_rec_next[i] = main_rec_reg[i] + MI'(1);
            end
            main_valid_next = valid_after;
            if (slot_found)
            begin
                main_key_next[slot]   = req_key_reg;
                main_val_next[slot]   = req_val_reg;
                main_rec_next[slot]   = '0;
                main_valid_next[slot] = 1'b1;
            end
        end
        else
        begin
            if (LW'(new_fill_reg) >= new_lim && new_fill_reg != '0)
            begin
                ev_inc = 1'b1;
                if (new_head_reg == NI'(NEW_DEPTH - 1))
                    new_head_next = '0;
                else
                    new_head_next = new_head_reg + NI'(1);
                new_fill_next = new_fill_reg - NC'(1);

                // Evicted key becomes the newest ghost.
                if (LW'(ghost_fill_reg) >= LW'(GHOST_DEPTH))
                begin
                    for (int j = 0; j < GHOST_DEPTH - 1; j++)
                        ghost_key_next[j] = ghost_key_reg[j+1];
                    ghost_key_next[GHOST_DEPTH-1] = old_key;
                end
                else
                begin
                    for (int j = 0; j < GHOST_DEPTH; j++)
                    begin
                        if (GC'(j) == ghost_fill_reg)
                            ghost_key_next[j] = old_key;
                    end
                    if (LW'(ghost_fill_reg) + LW'(1) > ghost_lim)
                    begin
                        for (int j = 0; j < GHOST_DEPTH - 1; j++)
                            ghost_key_next[j] = ghost_key_next[j+1];
                    end
                    else
                    begin
                        ghost_fill_next = ghost_fill_reg + GC'(1);
                    end
                end
            end
            if (LW'(new_fill_next) < LW'(NEW_DEPTH))
            begin
                sum = LW'(new_head_next) + LW'(new_fill_next);
                if (sum >= LW'(NEW_DEPTH))
                    sum = sum - LW'(NEW_DEPTH);
                wslot = sum[NI-1:0];
                new_key_next[wslot] = req_key_reg;
                new_val_next[wslot] = req_val_reg;
                new_fill_next       = new_fill_next + NC'(1);
            end
        end

        evicts_next = ev_inc ? tqcp_pkg::sat_inc(evicts_reg) : evicts_reg;
        out_item_next.hit_count      = hits_next;
        out_item_next.miss_count     = misses_next;
        out_item_next.eviction_count = evicts_next;
    end

    // Control state, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_limit_reg  <= 5'd16;
            new_limit_reg   <= 4'd8;
            ghost_limit_reg <= 5'd16;
            main_valid_reg  <= '0;
            for (int i = 0; i < MAIN_DEPTH; i++)
                main_rec_reg[i] <= '0;
            new_head_reg    <= '0;
            new_fill_reg    <= '0;
            ghost_fill_reg  <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tqcp_pkg::CFG_MAIN_LIMIT:  main_limit_reg  <= cfg_data[4:0];
                    tqcp_pkg::CFG_NEW_LIMIT:   new_limit_reg   <= cfg_data[3:0];
                    tqcp_pkg::CFG_GHOST_LIMIT: ghost_limit_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.update)
            begin
                main_valid_reg <= main_valid_next;
                main_rec_reg   <= main_rec_next;
                new_head_reg   <= new_head_next;
                new_fill_reg   <= new_fill_next;
                ghost_fill_reg <= ghost_fill_next;
                hits_reg       <= hits_next;
                misses_reg     <= misses_next;
                evicts_reg     <= evicts_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_mode_reg <= in_item.mode;
            req_key_reg  <= in_item.lookup_key[KW-1:0];
            req_val_reg  <= in_item.store_value;
        end
        if (cmd.match)
        begin
            main_hit_reg  <= main_hit_c;
            main_idx_reg  <= main_idx_c;
            main_cnt_reg  <= main_cnt_c;
            new_hit_reg   <= new_hit_c;
            new_idx_reg   <= new_idx_c;
            ghost_hit_reg <= ghost_hit_c;
            ghost_pos_reg <= ghost_pos_c;
        end
        if (cmd.update)
        begin
            main_key_reg  <= main_key_next;
            main_val_reg  <= main_val_next;
            new_key_reg   <= new_key_next;
            new_val_reg   <= new_val_next;
            ghost_key_reg <= ghost_key_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

>>> design/two_queue_cache_policy_unit.sv
// ----------------------------------------------------------------------------
// two_queue_cache_policy_unit
// Key-value cache with 2Q replacement: a FIFO of new entries, a FIFO of
// ghost keys and an LRU main store.
// ----------------------------------------------------------------------------
// Each request is accepted, then goes through a match pass that compares the
// key against every entry of the three stores at once, then an update pass
// that applies the replacement decision and loads the result register. A new
// request is accepted in the cycle after the update, even while the previous
// result still waits on out_stall; the update itself waits while that result
// has not been taken. Limits may be changed only while no request is in
// flight.
module two_queue_cache_policy_unit
#(
    parameter int MAIN_DEPTH  = 16,
    parameter int NEW_DEPTH   = 8,
    parameter int GHOST_DEPTH = 16,
    parameter int KEY_BITS    = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tqcp_pkg::req_t                  in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tqcp_pkg::rsp_t                  out_item,
    input  logic                            cfg_we,
    input  logic [tqcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tqcp_pkg::CFG_DATA_W-1:0] cfg_data
);

    tqcp_pkg::cmd_t cmd;

    tqcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tqcp_datapath
    #(
        .MAIN_DEPTH  (MAIN_DEPTH),
        .NEW_DEPTH   (NEW_DEPTH),
        .GHOST_DEPTH (GHOST_DEPTH),
        .KEY_BITS    (KEY_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

>>> tb/sv/tqcp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tqcp_checker
// Watches the request and result channels of the 2Q cache policy unit, keeps
// its own copy of the three stores and the counters, predicts every result
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module tqcp_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  tqcp_pkg::req_t                  in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  tqcp_pkg::rsp_t                  out_item,
    input  logic                            cfg_we,
    input  logic [tqcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tqcp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);

    localparam int AM_N = 16;
    localparam int A1_N = 8;
    localparam int GH_N = 16;

    logic [4:0]  am_lim;
    logic [3:0]  a1_lim;
    logic [4:0]  gh_lim;

    logic [31:0] am_key [AM_N];
    logic [31:0] am_val [AM_N];
    int          am_age [AM_N];
    bit          am_ok  [AM_N];
    logic [31:0] a1_key [A1_N];
    logic [31:0] a1_val [A1_N];
    int          a1_head, a1_fill;
    logic [31:0] gh_key [GH_N];
    int          gh_head, gh_fill;
    logic [31:0] hits, misses, evicts;

    tqcp_pkg::rsp_t expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void make_recent(input int s);
        int r;
        r = am_age[s];
        for (int i = 0; i < AM_N; i++)
            if (am_ok[i] && am_age[i] < r) am_age[i]++;
        am_age[s] = 0;
    endfunction

    function automatic void push_ghost(input logic [31:0] k);
        int lim;
        lim = clamp(gh_lim, 0, GH_N);
        if (gh_fill >= GH_N)
        begin
            gh_head = (gh_head + 1) % GH_N;
            gh_fill--;
            gh_key[(gh_head + gh_fill) % GH_N] = k;
            gh_fill++;
            return;
        end
        gh_key[(gh_head + gh_fill) % GH_N] = k;
        gh_fill++;
        if (gh_fill > lim)
        begin
            gh_head = (gh_head + 1) % GH_N;
            gh_fill--;
        end
    endfunction

    function automatic void promote(input logic [31:0] k, input logic [31:0] v);
        int cnt, victim, slot, lim;
        cnt = 0;
        victim = -1;
        slot = -1;
        lim = clamp(am_lim, 1, AM_N);
        for (int i = 0; i < AM_N; i++)
        begin
            if (am_ok[i])
            begin
                cnt++;
                if (victim < 0 || am_age[i] > am_age[victim]) victim = i;
            end
        end
        if (cnt >= lim && victim >= 0)
        begin
            am_ok[victim] = 0;
            evicts = bump(evicts);
        end
        for (int i = 0; i < AM_N; i++)
        begin
            if (am_ok[i]) am_age[i]++;
            else if (slot < 0) slot = i;
        end
        if (slot >= 0)
        begin
            am_key[slot] = k;
            am_val[slot] = v;
            am_age[slot] = 0;
            am_ok[slot]  = 1;
        end
    endfunction

    function automatic tqcp_pkg::rsp_t predict_lookup(input tqcp_pkg::req_t rq);
        tqcp_pkg::rsp_t r;
        logic [31:0]    k, v, old;
        int             s, n, g, lim;
        k = rq.lookup_key;
        v = rq.store_value;
        r = '0;
        s = -1;
        n = -1;
        g = -1;
        for (int i = 0; i < AM_N; i++)
            if (s < 0 && am_ok[i] && am_key[i] == k) s = i;
        if (s < 0)
            for (int i = 0; i < a1_fill; i++)
                if (n < 0 && a1_key[(a1_head + i) % A1_N] == k) n = (a1_head + i) % A1_N;
        if (!rq.mode)
        begin
            if (s >= 0)
            begin
                make_recent(s);
                r.hit = 1;
                r.read_value = am_val[s];
            end
            else if (n >= 0)
            begin
                r.hit = 1;
                r.read_value = a1_val[n];
            end
            if (r.hit) hits = bump(hits);
            else misses = bump(misses);
        end
        else if (s >= 0)
        begin
            am_val[s] = v;
            make_recent(s);
            r.hit = 1;
        end
        else if (n >= 0)
        begin
            a1_val[n] = v;
            r.hit = 1;
        end
        else
        begin
            for (int i = 0; i < gh_fill; i++)
                if (g < 0 && gh_key[(gh_head + i) % GH_N] == k) g = i;
            if (g >= 0)
            begin
                for (int i = g; i + 1 < gh_fill; i++)
                    gh_key[(gh_head + i) % GH_N] = gh_key[(gh_head + i + 1) % GH_N];
                gh_fill--;
                promote(k, v);
            end
            else
            begin
                lim = clamp(a1_lim, 1, A1_N);
                if (a1_fill >= lim && a1_fill > 0)
                begin
                    old = a1_key[a1_head];
                    a1_head = (a1_head + 1) % A1_N;
                    a1_fill--;
                    evicts = bump(evicts);
                    push_ghost(old);
                end
                if (a1_fill < A1_N)
                begin
                    a1_key[(a1_head + a1_fill) % A1_N] = k;
                    a1_val[(a1_head + a1_fill) % A1_N] = v;
                    a1_fill++;
                end
            end
        end
        r.hit_count = hits;
        r.miss_count = misses;
        r.eviction_count = evicts;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tqcp_pkg::rsp_t want;
        if (!rst_n)
        begin
            am_lim = 5'd16;
            a1_lim = 4'd8;
            gh_lim = 5'd16;
            for (int i = 0; i < AM_N; i++)
            begin
                am_ok[i] = 0;
                am_age[i] = 0;
            end
            a1_head = 0;
            a1_fill = 0;
            gh_head = 0;
            gh_fill = 0;
            hits = '0;
            misses = '0;
            evicts = '0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tqcp_pkg::CFG_MAIN_LIMIT:  am_lim = cfg_data;
                    tqcp_pkg::CFG_NEW_LIMIT:   a1_lim = cfg_data[3:0];
                    tqcp_pkg::CFG_GHOST_LIMIT: gh_lim = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_item);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.hit !== want.hit
                        || out_item.read_value !== want.read_value
                        || out_item.hit_count !== want.hit_count
                        || out_item.miss_count !== want.miss_count
                        || out_item.eviction_count !== want.eviction_count)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want,
                                 out_item);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_lookup(in_item));
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives get and put requests into the 2Q cache policy unit under several
// limit settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    tqcp_pkg::req_t                  in_item;
    logic                            out_valid;
    logic                            out_stall;
    tqcp_pkg::rsp_t                  out_item;
    logic                            cfg_we;
    logic [tqcp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tqcp_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              fail_count;
    int                              pending;
    int                              send_idle_pct;
    int                              stall_pct;
    logic [31:0]                     key_pool [12];

    two_queue_cache_policy_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tqcp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // The receiver stalls at random, changing only at the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Entered and left at a falling edge. Valid stays high after the accept
    // until the next request or a drain replaces it; the unit stalls meanwhile.
    task automatic send_request(input logic mode, input logic [31:0] k,
                                input logic [31:0] v);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{mode: mode, lookup_key: k, store_value: v};
        // Stall only changes at the rising edge, so its value here holds
        // for the coming edge.
        do
        begin
            accepted = !in_stall;
            @(negedge clk);
        end
        while (!accepted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_limits(input logic [4:0] am, input logic [4:0] a1,
                              input logic [4:0] gh);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= tqcp_pkg::CFG_MAIN_LIMIT;
        cfg_data <= am;
        @(negedge clk);
        cfg_index <= tqcp_pkg::CFG_NEW_LIMIT;
        cfg_data <= a1;
        @(negedge clk);
        cfg_index <= tqcp_pkg::CFG_GHOST_LIMIT;
        cfg_data <= gh;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly keys from a small pool so that entries move through all three
    // stores; now and then a fully random key.
    task automatic random_phase(input int count);
        logic [31:0] k;
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(11)];
            send_request(1'($urandom_range(1)), k, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tqcp_pkg::CFG_MAIN_LIMIT;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 12; i++)
            key_pool[i] = (i < 2) ? ((i == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: misses, extremes, ghost creation and promotion.
        set_limits(5'd1, 5'd1, 5'd16);
        send_request(1'b0, 32'h8000_0000, 32'h0);
        send_request(1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h8000_0000, 32'h0);
        send_request(1'b1, 32'h8000_0000, 32'h1234_5678);
        send_request(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(1'b0, 32'h8000_0000, 32'h0);
        send_request(1'b1, 32'h8000_0000, 32'h0000_0001);
        send_request(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0, 32'h7FFF_FFFF);
        send_request(1'b1, 32'hFFFF_FFFF, 32'h5555_5555);
        send_request(1'b1, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send_request(1'b1, 32'h0, 32'h0);
        send_request(1'b0, 32'h7FFF_FFFF, 32'h0);
        // Ghost limit zero drops the ghost at once.
        set_limits(5'd0, 5'd0, 5'd0);
        send_request(1'b1, 32'h0000_0011, 32'h1);
        send_request(1'b1, 32'h0000_0022, 32'h2);
        send_request(1'b1, 32'h0000_0011, 32'h3);
        send_request(1'b0, 32'h0000_0011, 32'h0);
        // Limits above the depth, then lowered below the fill.
        set_limits(5'd31, 5'd15, 5'd31);
        random_phase(40);
        set_limits(5'd2, 5'd2, 5'd1);
        random_phase(40);

        set_limits(5'd16, 5'd8, 5'd16);
        random_phase(80);
        send_idle_pct = 84;
        set_limits(5'd4, 5'd3, 5'd5);
        random_phase(70);
        drain_results();
        send_idle_pct = 0;
        stall_pct = 84;
        set_limits(5'd8, 5'd4, 5'd16);
        random_phase(70);
        send_idle_pct = 12;
        stall_pct = 12;
        set_limits(5'd1, 5'd8, 5'd0);
        random_phase(60);
        drain_results();

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
